[design/dkp_pkg.sv]
// Shared types, constants and the base decoder of the k-mer packer.
package dkp_pkg;

  localparam int unsigned MaxKDefault      = 32;
  localparam int unsigned IndexBitsDefault = 16;

  localparam int unsigned KmerBitsW  = 64;
  localparam int unsigned IndexOutW  = 16;
  localparam int unsigned CountOutW  = 16;
  localparam int unsigned SymbolW    = 8;
  localparam int unsigned KLenW      = 6;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned OutDataW   = KmerBitsW + IndexOutW + CountOutW;

  localparam logic [KLenW-1:0] KmerLengthReset = 6'd31;

  // Register index as seen on paddr[2].
  typedef enum logic [0:0] {
    REG_KMER_LENGTH = 1'b0,
    REG_UNUSED      = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_t;

  // A, C, G, T/U in both cases; newline counts as A; anything else is rejected.
  function automatic base_t decode_base(input logic [SymbolW-1:0] sym);
    base_t b;
    b.ok   = 1'b1;
    b.code = 2'd0;
    unique case (sym)
      8'h41, 8'h61, 8'h0A: b.code = 2'd0;
      8'h43, 8'h63:        b.code = 2'd1;
      8'h47, 8'h67:        b.code = 2'd2;
      8'h54, 8'h74, 8'h55, 8'h75: b.code = 2'd3;
      default: b.ok = 1'b0;
    endcase
    return b;
  endfunction

endpackage

[design/dna_kmer_two_bit_packer.sv]
// Top level of the sliding k-mer 2-bit packer.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata: symbol[7:0]; tuser: start_req[0]
//  m_axis    | out       | tdata: kmer_bits[63:0], window_index[79:64], accepted_count[95:80]
//  apb       | in/out    | kmer_length at byte address 0
//
// One symbol is taken per cycle unless a stalled output holds the input. The accepting
// edge loads the input register; the result register, which drives the output, is loaded
// from it when the staged symbol moves on. The decode, window shift and counter updates
// sit between those two registers. A stalled output only stops the input when the staged
// symbol produces a result; rejected or short windows pass through without waiting. Reset
// clears the window and counters and sets kmer_length to 31.
module dna_kmer_two_bit_packer #(
  parameter int unsigned MAX_K      = dkp_pkg::MaxKDefault,
  parameter int unsigned INDEX_BITS = dkp_pkg::IndexBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [dkp_pkg::SymbolW-1:0]   s_axis_tdata_i,   // symbol[7:0]
  input  logic [0:0]                    s_axis_tuser_i,   // start_req[0]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [dkp_pkg::OutDataW-1:0]  m_axis_tdata_o,   // kmer_bits, window_index, accepted_count
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [dkp_pkg::ApbAddrW-1:0]  paddr_i,
  input  logic [dkp_pkg::ApbDataW-1:0]  pwdata_i,
  output logic [dkp_pkg::ApbDataW-1:0]  prdata_o,
  output logic                          pready_o
);

  localparam int unsigned WinW  = 2 * MAX_K;
  localparam int unsigned RunW  = $clog2(MAX_K + 1);
  localparam int unsigned ShW   = $clog2(WinW + 1);
  localparam logic [INDEX_BITS-1:0] IdxMax = '1;

  // Configuration register.
  logic [dkp_pkg::KLenW-1:0] kmer_length_q;
  logic                      cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i
                  & (dkp_pkg::reg_idx_e'(paddr_i[2]) == dkp_pkg::REG_KMER_LENGTH);
  assign prdata_o = (dkp_pkg::reg_idx_e'(paddr_i[2]) == dkp_pkg::REG_KMER_LENGTH)
                  ? dkp_pkg::ApbDataW'(kmer_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q <= dkp_pkg::KmerLengthReset;
    end else if (cfg_wr) begin
      kmer_length_q <= pwdata_i[dkp_pkg::KLenW-1:0];
    end
  end

  // Effective k clamped to 1..MAX_K.
  logic [dkp_pkg::KLenW:0] k_eff;
  always_comb begin
    priority if (kmer_length_q == '0) begin
      k_eff = 7'd1;
    end else if (7'(kmer_length_q) > 7'(MAX_K)) begin
      k_eff = 7'(MAX_K);
    end else begin
      k_eff = 7'(kmer_length_q);
    end
  end

  // Input register stage.
  logic                        in_vld_q;
  logic [dkp_pkg::SymbolW-1:0] in_sym_q;
  logic                        in_start_q;

  // Sliding state.
  logic [WinW-1:0]       win_q, win_d;
  logic [RunW-1:0]       run_q, run_d;
  logic [INDEX_BITS-1:0] pos_q, pos_d;
  logic [INDEX_BITS-1:0] tally_q, tally_d;

  // Result register.
  logic                         out_vld_q;
  logic [dkp_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic            emit, out_free, stage_fire, in_fire;
  dkp_pkg::base_t  base;
  logic [WinW-1:0]       win_base;
  logic [RunW-1:0]       run_base;
  logic [INDEX_BITS-1:0] pos_base, tally_base, win_idx;
  logic [ShW-1:0]        sh_amt;
  logic [WinW-1:0]       kmer_sh;
  logic [INDEX_BITS+dkp_pkg::IndexOutW-1:0] idx_ext, cnt_ext;

  always_comb begin
    // A start request clears the state before its own symbol is taken.
    win_base   = in_start_q ? '0 : win_q;
    run_base   = in_start_q ? '0 : run_q;
    pos_base   = in_start_q ? '0 : pos_q;
    tally_base = in_start_q ? '0 : tally_q;

    base  = dkp_pkg::decode_base(in_sym_q);
    pos_d = (pos_base < IdxMax) ? pos_base + 1'b1 : pos_base;

    if (base.ok) begin
      if (WinW > 2) begin
        win_d = {base.code, win_base[WinW-1:2]};
      end else begin
        win_d = WinW'(base.code);
      end
      run_d = (run_base < RunW'(MAX_K)) ? run_base + 1'b1 : run_base;
    end else begin
      win_d = win_base >> 2;
      run_d = '0;
    end

    emit    = base.ok && (7'(run_d) >= k_eff);
    tally_d = (emit && (tally_base < IdxMax)) ? tally_base + 1'b1 : tally_base;

    sh_amt  = ShW'(WinW) - ShW'({k_eff, 1'b0});
    kmer_sh = win_d >> sh_amt;

    win_idx = (pos_base >= IdxMax) ? IdxMax
            : pos_base - INDEX_BITS'(k_eff) + 1'b1;
    idx_ext = {{dkp_pkg::IndexOutW{1'b0}}, win_idx};
    cnt_ext = {{dkp_pkg::IndexOutW{1'b0}}, tally_d};

    out_data_d = {cnt_ext[dkp_pkg::CountOutW-1:0], idx_ext[dkp_pkg::IndexOutW-1:0],
                  dkp_pkg::KmerBitsW'(kmer_sh)};
  end

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign stage_fire      = in_vld_q && (!emit || out_free);
  assign s_axis_tready_o = !in_vld_q || stage_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      win_q     <= '0;
      run_q     <= '0;
      pos_q     <= '0;
      tally_q   <= '0;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (stage_fire) begin
        in_vld_q <= 1'b0;
      end
      if (stage_fire && emit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      if (stage_fire) begin
        win_q   <= win_d;
        run_q   <= run_d;
        pos_q   <= pos_d;
        tally_q <= tally_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_sym_q   <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i[0];
    end
    if (stage_fire && emit) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

[design/dkp_checker.sv]
// Port-level checker for the k-mer packer and its bind statement.
module dkp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [dkp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic                          psel_i,
  input logic                          penable_i,
  input logic                          pwrite_i,
  input logic [dkp_pkg::ApbAddrW-1:0]  paddr_i,
  input logic [dkp_pkg::ApbDataW-1:0]  pwdata_i,
  input logic                          pready_o
);

  // Shadow of kmer_length, followed from the write transactions.
  logic [dkp_pkg::KLenW-1:0] klen_q;
  logic [dkp_pkg::KLenW:0]   k_chk;
  logic [dkp_pkg::KmerBitsW-1:0] kmer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= dkp_pkg::KmerLengthReset;
    end else if (psel_i && penable_i && pwrite_i && pready_o
                 && (dkp_pkg::reg_idx_e'(paddr_i[2]) == dkp_pkg::REG_KMER_LENGTH)) begin
      klen_q <= pwdata_i[dkp_pkg::KLenW-1:0];
    end
  end

  assign k_chk = (klen_q == '0) ? 7'd1 : 7'(klen_q);
  assign kmer  = m_axis_tdata_o[dkp_pkg::KmerBitsW-1:0];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[dkp_pkg::OutDataW-1 -: dkp_pkg::CountOutW] != '0)
    else $error("result carries a zero k-mer count");

  a_kmer_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (kmer >> {k_chk, 1'b0}) == '0)
    else $error("k-mer bits set above the window");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_o)
    else $error("pready dropped");

endmodule

bind dna_kmer_two_bit_packer dkp_checker u_dkp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .psel_i          (psel_i),
  .penable_i       (penable_i),
  .pwrite_i        (pwrite_i),
  .paddr_i         (paddr_i),
  .pwdata_i        (pwdata_i),
  .pready_o        (pready_o)
);

[dv/tb_dna_kmer_two_bit_packer.sv]
// Self-checking testbench of the sliding k-mer 2-bit packer.
`timescale 1ns / 1ps

module tb_dna_kmer_two_bit_packer;

  localparam int unsigned MaxK        = 32;
  localparam int unsigned SettleGap   = 8;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned SweepItems  = 50;
  localparam logic [15:0] IndexMax    = 16'hFFFF;

  typedef struct packed {
    logic [dkp_pkg::CountOutW-1:0] accepted_count;
    logic [dkp_pkg::IndexOutW-1:0] window_index;
    logic [dkp_pkg::KmerBitsW-1:0] kmer_bits;
  } kmer_result_t;

  typedef enum logic [1:0] {
    ROW_CONFIG,
    ROW_PREDICT,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic [dkp_pkg::SymbolW-1:0] sym;
    logic                        start;
    dkp_pkg::reg_idx_e           sel;
    logic [31:0]                 value;
    logic                        has_result;
    kmer_result_t                result;
  } stim_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         snd_valid;
  logic [dkp_pkg::SymbolW-1:0]  snd_symbol;
  logic [0:0]                   snd_start;
  logic                         rcv_ready;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [dkp_pkg::ApbAddrW-1:0] paddr;
  logic [dkp_pkg::ApbDataW-1:0] pwdata;

  logic                         s_axis_tready_o;
  logic                         m_axis_tvalid_o;
  logic [dkp_pkg::OutDataW-1:0] m_axis_tdata_o;  // kmer_bits, window_index, accepted_count
  logic [dkp_pkg::ApbDataW-1:0] prdata_o;
  logic                         pready_o;

  // Predicted copy of the block's state and its length register.
  logic [63:0]               window_q;
  logic [5:0]                run_q;
  logic [15:0]               pos_q;
  logic [15:0]               tally_q;
  logic [dkp_pkg::KLenW-1:0] k_len;

  kmer_result_t        expected_kmers[$];
  stim_row_t           directed_rows[$];
  int unsigned         mismatches;
  int unsigned         cycles;
  bit                  gap_en;
  bit                  stall_en;
  bit                  hold_req;

  dna_kmer_two_bit_packer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(snd_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (snd_symbol),  // symbol[7:0]
    .s_axis_tuser_i (snd_start),   // start_req[0]
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(rcv_ready),
    .m_axis_tdata_o (m_axis_tdata_o),  // kmer_bits, window_index, accepted_count
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata_o),
    .pready_o       (pready_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned k_eff();
    if (k_len == '0) return 1;
    if (k_len > MaxK) return MaxK;
    return k_len;
  endfunction

  function automatic bit base_code(input logic [7:0] sym, output logic [1:0] code);
    code = 2'd0;
    case (sym)
      "A", "a", 8'h0A:    code = 2'd0;
      "C", "c":           code = 2'd1;
      "G", "g":           code = 2'd2;
      "T", "t", "U", "u": code = 2'd3;
      default:            return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Advances the predicted window by one symbol; returns 1 when a k-mer is due.
  function automatic bit step_window(input logic [7:0] sym, input bit start,
                                     output kmer_result_t res);
    logic [1:0]  code;
    logic [15:0] at;
    int unsigned k;
    k   = k_eff();
    res = '0;
    if (start) begin
      window_q = '0;
      run_q    = '0;
      pos_q    = '0;
      tally_q  = '0;
    end
    at = pos_q;
    if (pos_q != IndexMax) pos_q++;
    if (!base_code(sym, code)) begin
      window_q = window_q >> 2;
      run_q    = '0;
      return 1'b0;
    end
    window_q = {code, window_q[63:2]};
    if (run_q < MaxK) run_q++;
    if (run_q < k) return 1'b0;
    if (tally_q != IndexMax) tally_q++;
    res.kmer_bits      = window_q >> (64 - 2 * k);
    res.window_index   = (at == IndexMax) ? IndexMax : at - 16'(k - 1);
    res.accepted_count = tally_q;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_base();
    case ($urandom_range(0, 10))
      0:       return "A";
      1:       return "a";
      2:       return "C";
      3:       return "c";
      4:       return "G";
      5:       return "g";
      6:       return "T";
      7:       return "t";
      8:       return "U";
      9:       return "u";
      default: return 8'h0A;
    endcase
  endfunction

  function automatic void add_sym(input logic [7:0] sym, input bit start);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_PREDICT;
    r.sym   = sym;
    r.start = start;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_typed(input logic [7:0] sym, input bit start, input bit has,
                                    input logic [63:0] kmer, input logic [15:0] idx,
                                    input logic [15:0] cnt);
    stim_row_t r;
    r            = '0;
    r.kind       = ROW_TYPED;
    r.sym        = sym;
    r.start      = start;
    r.has_result = has;
    r.result     = '{accepted_count: cnt, window_index: idx, kmer_bits: kmer};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input dkp_pkg::reg_idx_e sel, input logic [31:0] value);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_CONFIG;
    r.sel   = sel;
    r.value = value;
    directed_rows.push_back(r);
  endfunction

  // Offers one symbol and returns at the clock edge that accepts it.
  task automatic drive_symbol(input logic [7:0] sym, input bit start);
    if (gap_en && $urandom_range(0, 4) == 0) begin
      snd_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    snd_valid  <= 1'b1;
    snd_symbol <= sym;
    snd_start  <= start;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic feed_symbol(input logic [7:0] sym, input bit start);
    kmer_result_t res;
    if (step_window(sym, start, res)) expected_kmers.push_back(res);
    drive_symbol(sym, start);
  endtask

  task automatic wait_until_idle();
    snd_valid <= 1'b0;
    while (expected_kmers.size() != 0) @(posedge clk_i);
    // Rejected symbols may still be in flight without any result to wait on.
    repeat (SettleGap) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input dkp_pkg::reg_idx_e sel,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    rdata = prdata_o;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_length_readback();
    logic [31:0] rd;
    apb_access(1'b0, dkp_pkg::REG_KMER_LENGTH, '0, rd);
    if (rd != {26'd0, k_len}) report_mismatch("kmer_length readback", rd, k_len);
  endtask

  task automatic set_register(input dkp_pkg::reg_idx_e sel, input logic [31:0] value);
    logic [31:0] unused_rd;
    apb_access(1'b1, sel, value, unused_rd);
    if (sel == dkp_pkg::REG_KMER_LENGTH) k_len = value[dkp_pkg::KLenW-1:0];
    check_length_readback();
  endtask

  // Sets a new length with random upper data bits, which the block must drop.
  task automatic set_length(input logic [5:0] len);
    wait_until_idle();
    set_register(dkp_pkg::REG_KMER_LENGTH, ($urandom & 32'hFFFF_FFC0) | len);
  endtask

  // Runs of valid bases, up to k + 24 long and so often long enough to fill the window, broken by random bytes.
  task automatic run_random(input int unsigned n_items, input bit allow_start);
    int unsigned sent;
    int unsigned seg_len;
    int unsigned n_noise;
    bit          seg_start;
    sent = 0;
    while (sent < n_items) begin
      seg_len   = $urandom_range(0, k_eff() + 24);
      seg_start = allow_start && ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < seg_len; i++) begin
        feed_symbol(pick_base(), seg_start && i == 0);
      end
      n_noise = $urandom_range(0, 2);
      for (int unsigned i = 0; i < n_noise; i++) begin
        feed_symbol(8'($urandom_range(0, 255)), allow_start && $urandom_range(0, 7) == 0);
      end
      sent += seg_len + n_noise;
    end
  endtask

  // Output side: random stalls, plus one long hold-off when the sender asks.
  initial begin
    rcv_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        rcv_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (stall_en && $urandom_range(0, 4) == 0) begin
        rcv_ready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(posedge clk_i);
      end else begin
        rcv_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    kmer_result_t got;
    kmer_result_t want;
    if (rst_ni && m_axis_tvalid_o && rcv_ready) begin
      got = kmer_result_t'(m_axis_tdata_o);
      if (expected_kmers.size() == 0) begin
        report_mismatch("result with nothing expected", got.kmer_bits, '0);
      end else begin
        want = expected_kmers.pop_front();
        if (got.kmer_bits != want.kmer_bits)
          report_mismatch("kmer_bits", got.kmer_bits, want.kmer_bits);
        if (got.window_index != want.window_index)
          report_mismatch("window_index", got.window_index, want.window_index);
        if (got.accepted_count != want.accepted_count)
          report_mismatch("accepted_count", got.accepted_count, want.accepted_count);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("dna_kmer_two_bit_packer verification failed");
      $finish;
    end
  end

  initial begin
    kmer_result_t unused_res;
    rst_ni     <= 1'b0;
    snd_valid  <= 1'b0;
    snd_symbol <= '0;
    snd_start  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    mismatches = 0;
    cycles     = 0;
    hold_req   = 1'b0;
    gap_en     = 1'b1;
    stall_en   = 1'b1;
    window_q   = '0;
    run_q      = '0;
    pos_q      = '0;
    tally_q    = '0;
    k_len      = dkp_pkg::KmerLengthReset;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_length_readback();

    // Length 0 behaves as 1: every base is its own k-mer.
    add_cfg(dkp_pkg::REG_KMER_LENGTH, 32'd0);
    add_typed("A", 1'b1, 1'b1, 64'd0, 16'd0, 16'd1);
    add_typed("T", 1'b0, 1'b1, 64'd3, 16'd1, 16'd2);
    add_typed("n", 1'b0, 1'b0, 64'd0, 16'd0, 16'd0);
    add_typed("c", 1'b0, 1'b1, 64'd1, 16'd3, 16'd3);
    add_typed(8'h0A, 1'b0, 1'b1, 64'd0, 16'd4, 16'd4);
    add_typed("u", 1'b0, 1'b1, 64'd3, 16'd5, 16'd5);
    add_typed("g", 1'b0, 1'b1, 64'd2, 16'd6, 16'd6);
    add_typed("G", 1'b0, 1'b1, 64'd2, 16'd7, 16'd7);
    add_typed("U", 1'b0, 1'b1, 64'd3, 16'd8, 16'd8);
    add_typed("a", 1'b0, 1'b1, 64'd0, 16'd9, 16'd9);
    add_typed("C", 1'b0, 1'b1, 64'd1, 16'd10, 16'd10);
    add_typed("N", 1'b0, 1'b0, 64'd0, 16'd0, 16'd0);
    add_typed(8'hFF, 1'b0, 1'b0, 64'd0, 16'd0, 16'd0);
    add_typed(8'h00, 1'b0, 1'b0, 64'd0, 16'd0, 16'd0);
    // Pairs: an ambiguity code breaks the window and the run starts over.
    add_cfg(dkp_pkg::REG_KMER_LENGTH, 32'd2);
    add_typed("C", 1'b1, 1'b0, 64'd0, 16'd0, 16'd0);
    add_typed("G", 1'b0, 1'b1, 64'd9, 16'd0, 16'd1);
    add_typed("R", 1'b0, 1'b0, 64'd0, 16'd0, 16'd0);
    add_typed("T", 1'b0, 1'b0, 64'd0, 16'd0, 16'd0);
    add_typed("A", 1'b0, 1'b1, 64'd3, 16'd3, 16'd2);
    // Growing k in the middle of a buffer, then a write to an unmapped address.
    add_cfg(dkp_pkg::REG_KMER_LENGTH, 32'd3);
    add_sym("G", 1'b0);
    add_cfg(dkp_pkg::REG_UNUSED, 32'd1);
    add_sym("C", 1'b0);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CONFIG: begin
          wait_until_idle();
          set_register(directed_rows[i].sel, directed_rows[i].value);
        end
        ROW_PREDICT: feed_symbol(directed_rows[i].sym, directed_rows[i].start);
        default: begin
          void'(step_window(directed_rows[i].sym, directed_rows[i].start, unused_res));
          if (directed_rows[i].has_result) expected_kmers.push_back(directed_rows[i].result);
          drive_symbol(directed_rows[i].sym, directed_rows[i].start);
        end
      endcase
    end

    // Full-width window while the output is held off long enough to stall the input.
    set_length(6'd32);
    hold_req = 1'b1;
    run_random(150, 1'b1);
    set_length(6'd63);
    run_random(120, 1'b1);

    // A buffer at k of 1 with both sides at full rate.
    set_length(6'd1);
    gap_en   = 1'b0;
    stall_en = 1'b0;
    for (int unsigned i = 0; i < SweepItems; i++) begin
      if ($urandom_range(0, 255) == 0) feed_symbol(8'($urandom_range(0, 255)), i == 0);
      else feed_symbol(pick_base(), i == 0);
    end
    gap_en   = 1'b1;
    stall_en = 1'b1;
    // Same buffer, larger k: the new length applies from the next symbol on.
    set_length(6'd5);
    run_random(60, 1'b0);

    set_length(6'd0);
    run_random(100, 1'b1);
    set_length(6'd33);
    run_random(120, 1'b1);
    set_length(6'd31);
    run_random(150, 1'b1);
    set_length(6'd2);
    run_random(100, 1'b1);
    for (int unsigned p = 0; p < 3; p++) begin
      set_length(6'($urandom_range(0, 63)));
      run_random(80, 1'b1);
    end

    // Closing stretch at full rate on both sides.
    set_length(6'd17);
    gap_en   = 1'b0;
    stall_en = 1'b0;
    run_random(150, 1'b1);

    wait_until_idle();
    if (mismatches == 0) begin
      $display("dna_kmer_two_bit_packer verification clean");
    end else begin
      $display("dna_kmer_two_bit_packer verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/dkp_pkg.sv
design/dna_kmer_two_bit_packer.sv
design/dkp_checker.sv
dv/tb_dna_kmer_two_bit_packer.sv
